// File: sv/pnfe_pkg.sv
// ---------------------------------------------------------------------------
// pnfe_pkg: shared types and codes for the Petri net firing engine
// Holds operation and status codes, controller states and the command
// struct that runs from the controller to the datapath.
// ---------------------------------------------------------------------------
package pnfe_pkg;

  // Fixed field widths of the item and result ports
  localparam int FUNC_W    = 3;
  localparam int IDX_W     = 4;
  localparam int VALUE_W   = 16;
  localparam int TOK_OUT_W = 16;
  localparam int STATUS_W  = 2;

  // Operation codes; codes 6 and 7 behave as a query
  typedef enum logic [FUNC_W-1:0] {
    FN_SET_IN  = 3'd0,
    FN_SET_OUT = 3'd1,
    FN_SET_TOK = 3'd2,
    FN_FIRE    = 3'd3,
    FN_CLEAR   = 3'd4,
    FN_QUERY   = 3'd5
  } func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture item, read weight rows
    logic commit;  // update net state, load result register
  } dp_cmd_t;

endpackage

// File: sv/petri_net_firing_engine.sv
// ---------------------------------------------------------------------------
// petri_net_firing_engine: place/transition net with firing rule
// Holds arc weights and a marking; items edit the net, query it or fire.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries func_i, place_index_i,
//   transition_index_i and value_i. Output channel (out_valid_o/out_ready_i)
//   returns enabled_o, fired_o, tokens_o and status_o, one result per item.
//   On the input transfer the transition's weight row is read from both
//   weight memories; at commit all places are tested in parallel, the
//   marking is updated and the result register is loaded. One item is taken
//   at a time: in_ready_o stays low from the transfer until commit.
//   A result waiting in the output register does not block the next item:
//   it is read and held until commit, which waits only while the register
//   is still full and out_ready_i is low.
//   Reset clears the marking and all row valid bits, so every weight reads
//   as zero at once; no clearing pass. Clear-arcs drops the valid bits.
// ---------------------------------------------------------------------------
module petri_net_firing_engine import pnfe_pkg::*; #(
  parameter int NUM_PLACES      = 16,
  parameter int NUM_TRANSITIONS = 16,
  parameter int WEIGHT_BITS     = 8,
  parameter int TOKEN_BITS      = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [IDX_W-1:0]     place_index_i,
  input  logic [IDX_W-1:0]     transition_index_i,
  input  logic [VALUE_W-1:0]   value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 enabled_o,
  output logic                 fired_o,
  output logic [TOK_OUT_W-1:0] tokens_o,
  output logic [STATUS_W-1:0]  status_o
);

  dp_cmd_t cmd;

  // Sequencing
  pnfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Net state and firing logic
  pnfe_datapath #(
    .NUM_PLACES      (NUM_PLACES),
    .NUM_TRANSITIONS (NUM_TRANSITIONS),
    .WEIGHT_BITS     (WEIGHT_BITS),
    .TOKEN_BITS      (TOKEN_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .func_i             (func_i),
    .place_index_i      (place_index_i),
    .transition_index_i (transition_index_i),
    .value_i            (value_i),
    .enabled_o          (enabled_o),
    .fired_o            (fired_o),
    .tokens_o           (tokens_o),
    .status_o           (status_o)
  );

endmodule

// File: sv/pnfe_ctrl.sv
// ---------------------------------------------------------------------------
// pnfe_ctrl: sequencing controller
// Takes one item at a time, issues the load and commit commands and keeps
// the valid flag of the result register.
// ---------------------------------------------------------------------------
module pnfe_ctrl import pnfe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        // commit only when the result slot is free or drains this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: sv/pnfe_datapath.sv
// ---------------------------------------------------------------------------
// pnfe_datapath: net state, weight memories and firing logic
// Weights are stored one row per transition (all places side by side), so
// a single read gives the whole column needed to test and fire. Each row
// has a valid bit; an invalid row reads as all-zero weights.
// ---------------------------------------------------------------------------
module pnfe_datapath import pnfe_pkg::*; #(
  parameter int NUM_PLACES      = 16,
  parameter int NUM_TRANSITIONS = 16,
  parameter int WEIGHT_BITS     = 8,
  parameter int TOKEN_BITS      = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [IDX_W-1:0]     place_index_i,
  input  logic [IDX_W-1:0]     transition_index_i,
  input  logic [VALUE_W-1:0]   value_i,
  output logic                 enabled_o,
  output logic                 fired_o,
  output logic [TOK_OUT_W-1:0] tokens_o,
  output logic [STATUS_W-1:0]  status_o
);

  localparam int PA_W  = $clog2(NUM_PLACES);
  localparam int TA_W  = $clog2(NUM_TRANSITIONS);
  localparam int ROW_W = NUM_PLACES * WEIGHT_BITS;
  localparam int SUM_W = ((TOKEN_BITS > WEIGHT_BITS) ? TOKEN_BITS : WEIGHT_BITS) + 1;
  localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = '1;
  localparam logic [SUM_W-1:0]      TMAX_X    = SUM_W'(TOKEN_MAX);

  // Item registers
  logic [FUNC_W-1:0]  func_q;
  logic [IDX_W-1:0]   p_q;
  logic [IDX_W-1:0]   t_q;
  logic [VALUE_W-1:0] value_q;

  // Weight memories and row valid bits
  logic [ROW_W-1:0]           inw_mem  [NUM_TRANSITIONS];
  logic [ROW_W-1:0]           outw_mem [NUM_TRANSITIONS];
  logic [NUM_TRANSITIONS-1:0] inw_vld_q;
  logic [NUM_TRANSITIONS-1:0] outw_vld_q;
  logic [ROW_W-1:0]           inw_rd_q;
  logic [ROW_W-1:0]           outw_rd_q;
  logic                       inw_rd_vld_q;
  logic                       outw_rd_vld_q;

  // Marking
  logic [TOKEN_BITS-1:0] marking_q [NUM_PLACES];
  logic [TOKEN_BITS-1:0] marking_d [NUM_PLACES];

  // Result registers
  logic                 enabled_q;
  logic                 fired_q;
  logic                 fired_d;
  logic [TOK_OUT_W-1:0] tokens_q;
  logic [TOK_OUT_W-1:0] tokens_d;
  status_e              status_q;
  status_e              status_d;

  // Decode of incoming and held indices
  logic            t_ok_in;
  logic [TA_W-1:0] t_addr_in;
  logic            p_ok;
  logic            t_ok;
  logic [PA_W-1:0] p_addr;
  logic [TA_W-1:0] t_addr;

  assign t_ok_in   = 32'(transition_index_i) < NUM_TRANSITIONS;
  assign t_addr_in = TA_W'(transition_index_i);
  assign p_ok      = 32'(p_q) < NUM_PLACES;
  assign t_ok      = 32'(t_q) < NUM_TRANSITIONS;
  assign p_addr    = PA_W'(p_q);
  assign t_addr    = TA_W'(t_q);

  // Effective weight rows
  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] out_row;
  logic [ROW_W-1:0] new_in_row;
  logic [ROW_W-1:0] new_out_row;

  assign in_row  = inw_rd_vld_q  ? inw_rd_q  : '0;
  assign out_row = outw_rd_vld_q ? outw_rd_q : '0;

  // Write strobes from the operation decode
  logic inw_we;
  logic outw_we;
  logic clear_en;

  // Item capture and column read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q        <= func_i;
      p_q           <= place_index_i;
      t_q           <= transition_index_i;
      value_q       <= value_i;
      inw_rd_q      <= inw_mem[t_addr_in];
      outw_rd_q     <= outw_mem[t_addr_in];
      inw_rd_vld_q  <= t_ok_in ? inw_vld_q[t_addr_in]  : 1'b0;
      outw_rd_vld_q <= t_ok_in ? outw_vld_q[t_addr_in] : 1'b0;
    end
  end

  // Row writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && inw_we) begin
      inw_mem[t_addr] <= new_in_row;
    end
    if (cmd_i.commit && outw_we) begin
      outw_mem[t_addr] <= new_out_row;
    end
  end

  // Row valid bits: clear-arcs drops all rows at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inw_vld_q  <= '0;
      outw_vld_q <= '0;
    end else if (cmd_i.commit) begin
      if (clear_en) begin
        inw_vld_q  <= '0;
        outw_vld_q <= '0;
      end else begin
        if (inw_we) inw_vld_q[t_addr] <= 1'b1;
        if (outw_we) outw_vld_q[t_addr] <= 1'b1;
      end
    end
  end

  // Per-place enable test and firing update
  logic [NUM_PLACES-1:0] ge;
  logic [NUM_PLACES-1:0] fire_sat;
  logic [TOKEN_BITS-1:0] fire_mk [NUM_PLACES];

  for (genvar g = 0; g < NUM_PLACES; g++) begin : g_lane
    logic [SUM_W-1:0] m_x;
    logic [SUM_W-1:0] wi;
    logic [SUM_W-1:0] wo;
    logic [SUM_W-1:0] sum;
    assign m_x         = SUM_W'(marking_q[g]);
    assign wi          = SUM_W'(in_row[g*WEIGHT_BITS +: WEIGHT_BITS]);
    assign wo          = SUM_W'(out_row[g*WEIGHT_BITS +: WEIGHT_BITS]);
    assign ge[g]       = m_x >= wi;
    // no underflow when the transition is enabled
    assign sum         = m_x - wi + wo;
    assign fire_sat[g] = sum > TMAX_X;
    assign fire_mk[g]  = fire_sat[g] ? TOKEN_MAX : TOKEN_BITS'(sum);
  end

  logic en;
  assign en = t_ok && (&ge);

  // Token write with saturation
  logic [32:0]           val_x;
  logic                  tok_ovf;
  logic [TOKEN_BITS-1:0] tok_wr;

  assign val_x   = 33'(value_q);
  assign tok_ovf = |(val_x >> TOKEN_BITS);
  assign tok_wr  = tok_ovf ? TOKEN_MAX : TOKEN_BITS'(value_q);

  // Operation decode
  always_comb begin
    marking_d   = marking_q;
    new_in_row  = in_row;
    new_out_row = out_row;
    inw_we      = 1'b0;
    outw_we     = 1'b0;
    clear_en    = 1'b0;
    fired_d     = 1'b0;
    status_d    = ST_OK;
    case (func_q)
      FN_SET_IN: begin
        if (p_ok && t_ok) begin
          new_in_row[p_addr*WEIGHT_BITS +: WEIGHT_BITS] = WEIGHT_BITS'(value_q);
          inw_we = 1'b1;
        end
      end
      FN_SET_OUT: begin
        if (p_ok && t_ok) begin
          new_out_row[p_addr*WEIGHT_BITS +: WEIGHT_BITS] = WEIGHT_BITS'(value_q);
          outw_we = 1'b1;
        end
      end
      FN_SET_TOK: begin
        if (p_ok) begin
          marking_d[p_addr] = tok_wr;
          if (tok_ovf) status_d = ST_SATURATED;
        end
      end
      FN_FIRE: begin
        if (!en) begin
          status_d = ST_REFUSED;
        end else begin
          marking_d = fire_mk;
          fired_d   = 1'b1;
          if (|fire_sat) status_d = ST_SATURATED;
        end
      end
      FN_CLEAR: clear_en = 1'b1;
      default: ;
    endcase
    tokens_d = p_ok ? TOK_OUT_W'(marking_d[p_addr]) : '0;
  end

  // Marking register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLACES; i++) marking_q[i] <= '0;
    end else if (cmd_i.commit) begin
      marking_q <= marking_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      enabled_q <= en;
      fired_q   <= fired_d;
      tokens_q  <= tokens_d;
      status_q  <= status_d;
    end
  end

  assign enabled_o = enabled_q;
  assign fired_o   = fired_q;
  assign tokens_o  = tokens_q;
  assign status_o  = status_q;

endmodule

// File: sv/pnfe_checker.sv
// ---------------------------------------------------------------------------
// pnfe_checker: port-level checks for the firing engine
// Watches the top-level ports and is attached by the bind below.
// ---------------------------------------------------------------------------
module pnfe_checker import pnfe_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 enabled_o,
  input logic                 fired_o,
  input logic [TOK_OUT_W-1:0] tokens_o,
  input logic [STATUS_W-1:0]  status_o
);

  // Stalled result stays valid with tokens and status unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tokens_o) && $stable(status_o))
    else $error("stalled result changed");

  // A firing only happens on an enabled transition
  a_fire_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fired_o |-> enabled_o)
    else $error("fired without enable");

  // A fired item never reports a refusal
  a_fire_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fired_o |-> status_o != ST_REFUSED)
    else $error("fired item reports refusal");

  // Status carries a defined code
  a_stat_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_REFUSED || status_o == ST_SATURATED)
    else $error("undefined status code");

  // One item at a time: no transfer in the cycle after a transfer
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("back-to-back input transfer");

endmodule

bind petri_net_firing_engine pnfe_checker u_pnfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .enabled_o   (enabled_o),
  .fired_o     (fired_o),
  .tokens_o    (tokens_o),
  .status_o    (status_o)
);
